// ===== sv/compacting_key_value_table_top_defines.svh =====
// assertion macros used by the table top-level rtl
`ifndef COMPACTING_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// clocked check, masked while reset is asserted
`define CKVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define CKVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/ckvt_pkg.sv =====
`timescale 1ns / 1ps
package ckvt_pkg;

  // default sizes
  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned KEY_WIDTH_DEF = 64;
  localparam int unsigned KEY_W_MAX     = 64;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CNT_OUT_W     = 9;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // request payload
  typedef struct packed {
    logic [1:0]              cmd;
    logic [KEY_W_MAX-1:0]    key;
    logic signed [VAL_W-1:0] data_in;
  } req_t;

  // result payload
  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] data_out;
    logic [CNT_OUT_W-1:0]    entry_count;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_hit;
    logic       rd_en;
    logic       app_wr;
    logic       shift_wr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       rsp_ld;
    logic       rsp_hit_val;
    logic [1:0] rsp_status;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       scan_end;
    logic       rd_vld;
    logic       hit;
  } sts_t;

endpackage

// ===== sv/ckvt_datapath.sv =====
`timescale 1ns / 1ps
module ckvt_datapath import ckvt_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  ctl_t ctl_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // entry stores
  logic [KEY_WIDTH-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0]     val_mem [DEPTH];

  logic [1:0]           cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [VAL_W-1:0]     val_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        rd_addr_q;
  logic                 rd_vld_q;
  logic [KEY_WIDTH-1:0] rd_key_q;
  logic [VAL_W-1:0]     rd_val_q;
  rsp_t                 rsp_q, rsp_d;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [VAL_W-1:0]     wr_val;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key[KEY_WIDTH-1:0];
      val_q <= req_i.data_in;
    end
  end

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctl_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  // scan index: restarts at zero, or just past a hit for the shift
  always_comb begin
    idx_d = idx_q;
    if (ctl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctl_i.idx_hit) begin
      idx_d = CW'(rd_addr_q) + CW'(1);
    end else if (ctl_i.rd_en) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      rd_vld_q <= ctl_i.rd_en;
    end
  end

  // write port: append at the fill count or move a read entry down one place
  always_comb begin
    wr_en   = ctl_i.app_wr | ctl_i.shift_wr;
    wr_addr = cnt_q[AW-1:0];
    wr_key  = key_q;
    wr_val  = val_q;
    if (ctl_i.shift_wr) begin
      wr_addr = rd_addr_q - AW'(1);
      wr_key  = rd_key_q;
      wr_val  = rd_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_key_q  <= key_mem[idx_q[AW-1:0]];
      rd_val_q  <= val_mem[idx_q[AW-1:0]];
      rd_addr_q <= idx_q[AW-1:0];
    end
  end

  // status toward the controller
  always_comb begin
    sts_o.cmd      = cmd_q;
    sts_o.full     = (cnt_q == CW'(DEPTH));
    sts_o.scan_end = (idx_q == cnt_q);
    sts_o.rd_vld   = rd_vld_q;
    sts_o.hit      = rd_vld_q && (rd_key_q == key_q);
  end

  // result register, count taken after this request's update
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_d};

  always_comb begin
    rsp_d.status      = ctl_i.rsp_status;
    rsp_d.data_out    = ctl_i.rsp_hit_val ? rd_val_q : '0;
    rsp_d.entry_count = cnt_ext[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rsp_ld) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== sv/ckvt_ctrl.sv =====
`timescale 1ns / 1ps
module ckvt_ctrl import ckvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output ctl_t ctl_o,
  output logic busy,
  output logic done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // next state and datapath commands
  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load    = 1'b1;
          ctl_o.idx_clr = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts_i.cmd == CMD_INSERT && sts_i.full) begin
          ctl_o.rsp_ld     = 1'b1;
          ctl_o.rsp_status = ST_FULL;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else if (sts_i.cmd == CMD_INSERT || sts_i.cmd == CMD_DELETE ||
                     sts_i.cmd == CMD_FIND) begin
          state_d = S_SEARCH;
        end else begin
          // unused code: nothing changes
          ctl_o.rsp_ld     = 1'b1;
          ctl_o.rsp_status = ST_OK;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          priority if (sts_i.cmd == CMD_DELETE) begin
            ctl_o.idx_hit = 1'b1;
            state_d       = S_SHIFT;
          end else begin
            ctl_o.rsp_ld      = 1'b1;
            ctl_o.rsp_status  = (sts_i.cmd == CMD_INSERT) ? ST_DUP : ST_OK;
            ctl_o.rsp_hit_val = (sts_i.cmd == CMD_FIND);
            done_d            = 1'b1;
            state_d           = S_IDLE;
          end
        end else if (!sts_i.scan_end) begin
          ctl_o.rd_en = 1'b1;
        end else if (!sts_i.rd_vld) begin
          // all stored entries scanned without a match
          ctl_o.rsp_ld = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
          if (sts_i.cmd == CMD_INSERT) begin
            ctl_o.app_wr     = 1'b1;
            ctl_o.cnt_inc    = 1'b1;
            ctl_o.rsp_status = ST_OK;
          end else begin
            ctl_o.rsp_status = ST_MISS;
          end
        end
      end
      S_SHIFT: begin
        // read entry j+1 while writing the previous read, entry j, to j-1
        if (!sts_i.scan_end) begin
          ctl_o.rd_en = 1'b1;
        end
        if (sts_i.rd_vld) begin
          ctl_o.shift_wr = 1'b1;
        end
        if (sts_i.scan_end && !sts_i.rd_vld) begin
          ctl_o.cnt_dec    = 1'b1;
          ctl_o.rsp_ld     = 1'b1;
          ctl_o.rsp_status = ST_OK;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== sv/compacting_key_value_table_top.sv =====
`timescale 1ns / 1ps
// Key/value table of up to DEPTH entries kept densely in insertion order.
// A request (insert, delete or find) is taken when start is high and busy
// is low; its result appears on rsp_o with done_o high for exactly one cycle
// and must be captured then, as the receiver cannot hold it off. Every command
// other than an insert into a full table or an unused code walks the stored
// entries through the single registered read port of the entry memory, one
// entry per cycle, until a match or the end of the stored entries; a delete
// then shifts the entries after the match down, again one per cycle. The next
// request is taken in the cycle that done_o is high.
`include "compacting_key_value_table_top_defines.svh"
module compacting_key_value_table_top import ckvt_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  ctl_t ctl;
  sts_t sts;

  // sequencer
  ckvt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy),
    .done_o (done_o)
  );

  // entry memory, counters and result register
  ckvt_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

  // an accepted request always makes the block busy
  `CKVT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request accepted but not busy")
  // a result only follows work in progress
  `CKVT_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without a request")
  // one result per request: strobes never come back to back
  `CKVT_ASSERT_ALWAYS(a_done_single, done_o |=> !done_o, "result strobe repeated")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import ckvt_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEF;
  localparam int unsigned KEY_WIDTH      = KEY_WIDTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = DEPTH + 64;

  // software copy of the table, kept dense in insertion order
  class table_mirror;
    logic [KEY_W_MAX-1:0]    keys[$];
    logic signed [VAL_W-1:0] vals[$];
    rsp_t                    expected_q[$];
    int unsigned             mismatches;
    int unsigned             depth;
    logic [KEY_W_MAX-1:0]    key_mask;

    function new(int unsigned table_depth, int unsigned key_bits);
      depth      = table_depth;
      key_mask   = {KEY_W_MAX{1'b1}} >> (KEY_W_MAX - key_bits);
      mismatches = 0;
    endfunction

    // index of the key among the valid entries, -1 on a miss
    function int locate(logic [KEY_W_MAX-1:0] k);
      foreach (keys[i]) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // apply an accepted request and queue the response it must produce
    function void note_request(req_t r);
      rsp_t                 e;
      logic [KEY_W_MAX-1:0] k;
      int                   pos;
      e          = '0;
      e.status   = ST_OK;
      k          = r.key & key_mask;
      pos        = locate(k);
      case (r.cmd)
        CMD_INSERT: begin
          if (keys.size() >= depth) begin
            e.status = ST_FULL;
          end else if (pos >= 0) begin
            e.status = ST_DUP;
          end else begin
            keys.push_back(k);
            vals.push_back(r.data_in);
          end
        end
        CMD_DELETE: begin
          if (pos < 0) begin
            e.status = ST_MISS;
          end else begin
            keys.delete(pos);
            vals.delete(pos);
          end
        end
        CMD_FIND: begin
          if (pos < 0) e.status = ST_MISS;
          else e.data_out = vals[pos];
        end
        default: ;
      endcase
      e.entry_count = CNT_OUT_W'(keys.size());
      expected_q.push_back(e);
    endfunction

    function void flag(string field, logic [63:0] exp_v, logic [63:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, exp_v, got_v);
    endfunction

    // compare one response with the oldest expectation
    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        flag("unexpected response", 0, got);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) flag("status", e.status, got.status);
      if (got.data_out !== e.data_out) flag("data_out", e.data_out, got.data_out);
      if (got.entry_count !== e.entry_count) flag("entry_count", e.entry_count, got.entry_count);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  table_mirror mirror;
  bit          idle_en;
  int unsigned quiet_cycles;

  compacting_key_value_table_top #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) mirror.check_response(rsp_o);
  end

  // watchdog on cycles with no request or response
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one request, optionally after an idle burst, and wait for acceptance
  task automatic issue(input logic [1:0] c, input logic [63:0] k, input logic [31:0] d);
    req_t r;
    if (idle_en && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    r.cmd     = c;
    r.key     = k;
    r.data_in = d;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    mirror.note_request(r);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // stored key with the given bias, a one-bit neighbor of one, or a fresh key
  function automatic logic [63:0] pick_key(int unsigned hit_pct);
    logic [63:0] k;
    if (mirror.keys.size() == 0) return rand_word();
    k = mirror.keys[$urandom_range(mirror.keys.size() - 1)];
    if ($urandom_range(99) < hit_pct) return k;
    if ($urandom_range(3) == 0) return k ^ (64'd1 << $urandom_range(63));
    return rand_word();
  endfunction

  function automatic logic [1:0] pick_cmd(int unsigned w_ins, int unsigned w_del,
                                          int unsigned w_find);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < w_ins) return CMD_INSERT;
    if (roll < w_ins + w_del) return CMD_DELETE;
    if (roll < w_ins + w_del + w_find) return CMD_FIND;
    return CMD_UNUSED;
  endfunction

  // random requests with a given command mix
  task automatic run_mixed(int unsigned n, int unsigned w_ins, int unsigned w_del,
                           int unsigned w_find, int unsigned hit_pct);
    logic [1:0] c;
    repeat (n) begin
      c = pick_cmd(w_ins, w_del, w_find);
      issue(c, pick_key(c == CMD_INSERT ? hit_pct / 4 : hit_pct), $urandom);
    end
  endtask

  initial begin
    int unsigned failures;
    mirror  = new(DEPTH, KEY_WIDTH);
    idle_en = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, duplicates, compaction at the first, a middle and the last position
    issue(CMD_FIND,   64'h0, 32'h0);
    issue(CMD_DELETE, 64'h0, 32'h0);
    issue(CMD_UNUSED, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    issue(CMD_INSERT, 64'h0, 32'h8000_0000);
    issue(CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'h7fff_ffff);
    issue(CMD_INSERT, 64'h8000_0000_0000_0001, 32'hffff_ffff);
    issue(CMD_INSERT, 64'h0, 32'h0000_0005);
    issue(CMD_FIND,   64'h0, 32'h1);
    issue(CMD_FIND,   64'hffff_ffff_ffff_ffff, 32'h0);
    issue(CMD_FIND,   64'h0000_0000_0000_0001, 32'h0);
    issue(CMD_FIND,   64'h7fff_ffff_ffff_ffff, 32'h0);
    issue(CMD_INSERT, 64'h5555_5555_5555_5555, 32'h0);
    issue(CMD_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h1234_5678);
    issue(CMD_DELETE, 64'h8000_0000_0000_0001, 32'h0);
    issue(CMD_FIND,   64'hffff_ffff_ffff_ffff, 32'h0);
    issue(CMD_FIND,   64'haaaa_aaaa_aaaa_aaaa, 32'h0);
    issue(CMD_DELETE, 64'h0, 32'h0);
    issue(CMD_DELETE, 64'haaaa_aaaa_aaaa_aaaa, 32'h0);
    issue(CMD_DELETE, 64'haaaa_aaaa_aaaa_aaaa, 32'h0);
    issue(CMD_UNUSED, rand_word(), $urandom);
    issue(CMD_FIND,   64'h5555_5555_5555_5555, 32'h0);

    // random mix at low fill
    run_mixed(150, 40, 25, 30, 60);

    // fill the table to the top, with finds along the way
    while (mirror.keys.size() < DEPTH) begin
      if ($urandom_range(9) == 0) issue(CMD_FIND, pick_key(70), $urandom);
      else issue(CMD_INSERT, pick_key(5), $urandom);
    end

    // full table: inserts of new and present keys, deletes refilled later
    run_mixed(40, 55, 15, 25, 60);
    while (mirror.keys.size() < DEPTH) issue(CMD_INSERT, rand_word(), $urandom);
    issue(CMD_INSERT, mirror.keys[0], $urandom);
    issue(CMD_DELETE, mirror.keys[DEPTH - 1], 32'h0);
    issue(CMD_DELETE, mirror.keys[0], 32'h0);

    // last stretch without idle cycles, draining part of the table
    idle_en = 1'b0;
    run_mixed(100, 25, 40, 30, 70);
    start <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    failures = mirror.mismatches + mirror.pending();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
